// File: hdl/kepler_equation_solver_top_assert.svh
// ----------------------------------------------------------------------------
// Kepler equation solver assertion macros
// Concurrent assertion wrappers for simulation; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef KEPLER_EQUATION_SOLVER_TOP_ASSERT_SVH
`define KEPLER_EQUATION_SOLVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define KES_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kepler solver check failed");

// antecedent implies consequent in the next cycle
`define KES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kepler solver check failed");

`else

`define KES_ASSERT_SAME(label, clk, rst, ante, cons)
`define KES_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/kes_pkg.sv
// ----------------------------------------------------------------------------
// Kepler equation solver package
// Shared types, datapath commands and constant tables.
// ----------------------------------------------------------------------------
package kes_pkg;

   localparam int ANGLE_W     = 32;
   localparam int ECC_W       = 16;
   localparam int TOL_W       = 16;
   localparam int LIMIT_W     = 8;
   localparam int STEP_BITS   = 79;   // 32 numerator bits plus 46 fraction plus round bit
   localparam int STEP_CNT_W  = 7;
   localparam int HORNER_LAST = 6;

   localparam logic [30:0] TRIG_ONE    = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // datapath commands
   localparam logic [4:0] OP_NOP     = 5'd0;
   localparam logic [4:0] OP_LOAD    = 5'd1;
   localparam logic [4:0] OP_ABS     = 5'd2;
   localparam logic [4:0] OP_REDUCE  = 5'd3;
   localparam logic [4:0] OP_SQR     = 5'd4;
   localparam logic [4:0] OP_SQRND   = 5'd5;
   localparam logic [4:0] OP_HMUL    = 5'd6;
   localparam logic [4:0] OP_HRND    = 5'd7;
   localparam logic [4:0] OP_HREC    = 5'd8;
   localparam logic [4:0] OP_HCOR    = 5'd9;
   localparam logic [4:0] OP_HSAVE   = 5'd10;
   localparam logic [4:0] OP_SVMUL   = 5'd11;
   localparam logic [4:0] OP_SVRND   = 5'd12;
   localparam logic [4:0] OP_QUAD    = 5'd13;
   localparam logic [4:0] OP_ESMUL   = 5'd14;
   localparam logic [4:0] OP_RES     = 5'd15;
   localparam logic [4:0] OP_DMUL    = 5'd16;
   localparam logic [4:0] OP_DSET    = 5'd17;
   localparam logic [4:0] OP_DIVST   = 5'd18;
   localparam logic [4:0] OP_DIVSTEP = 5'd19;
   localparam logic [4:0] OP_UPDATE  = 5'd20;
   localparam logic [4:0] OP_OUT     = 5'd21;

   typedef struct packed {
      logic [4:0] op;
      logic       cos_sel;
      logic [2:0] term;
   } cmd_type;

   typedef struct packed {
      logic red_more;
      logic div_last;
      logic mag_ok;
      logic limit_hit;
   } status_type;

   // taylor term divisors
   function automatic logic [7:0] horner_div(input logic cos_sel, input logic [2:0] term);
      logic [7:0] v;
      unique case ({cos_sel, term})
         4'b0_000: v = 8'd210;
         4'b0_001: v = 8'd156;
         4'b0_010: v = 8'd110;
         4'b0_011: v = 8'd72;
         4'b0_100: v = 8'd42;
         4'b0_101: v = 8'd20;
         4'b0_110: v = 8'd6;
         4'b1_000: v = 8'd182;
         4'b1_001: v = 8'd132;
         4'b1_010: v = 8'd90;
         4'b1_011: v = 8'd56;
         4'b1_100: v = 8'd30;
         4'b1_101: v = 8'd12;
         4'b1_110: v = 8'd2;
         default:  v = 8'd1;
      endcase
      return v;
   endfunction

   // floor(2^32 / divisor), quotient estimate is low by at most one
   function automatic logic [31:0] horner_recip(input logic cos_sel, input logic [2:0] term);
      logic [31:0] v;
      unique case ({cos_sel, term})
         4'b0_000: v = 32'd20452225;
         4'b0_001: v = 32'd27531841;
         4'b0_010: v = 32'd39045157;
         4'b0_011: v = 32'd59652323;
         4'b0_100: v = 32'd102261126;
         4'b0_101: v = 32'd214748364;
         4'b0_110: v = 32'd715827882;
         4'b1_000: v = 32'd23598721;
         4'b1_001: v = 32'd32537631;
         4'b1_010: v = 32'd47721858;
         4'b1_011: v = 32'd76695844;
         4'b1_100: v = 32'd143165576;
         4'b1_101: v = 32'd357913941;
         4'b1_110: v = 32'd2147483648;
         default:  v = 32'hFFFF_FFFF;
      endcase
      return v;
   endfunction

   function automatic logic [ANGLE_W-1:0] sat_angle(input logic signed [35:0] v);
      logic [ANGLE_W-1:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[ANGLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/kes_ctrl.sv
// ----------------------------------------------------------------------------
// Kepler equation solver controller
// Sequences the Newton passes and the result handshake.
// ----------------------------------------------------------------------------
module kes_ctrl
   import kes_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_ABS   = 5'd1;
   localparam logic [4:0] S_RED   = 5'd2;
   localparam logic [4:0] S_SQRND = 5'd3;
   localparam logic [4:0] S_HMUL  = 5'd4;
   localparam logic [4:0] S_HRND  = 5'd5;
   localparam logic [4:0] S_HREC  = 5'd6;
   localparam logic [4:0] S_HCOR  = 5'd7;
   localparam logic [4:0] S_HSAVE = 5'd8;
   localparam logic [4:0] S_SVMUL = 5'd9;
   localparam logic [4:0] S_SVRND = 5'd10;
   localparam logic [4:0] S_QUAD  = 5'd11;
   localparam logic [4:0] S_ESMUL = 5'd12;
   localparam logic [4:0] S_RES   = 5'd13;
   localparam logic [4:0] S_DMUL  = 5'd14;
   localparam logic [4:0] S_DSET  = 5'd15;
   localparam logic [4:0] S_DIVST = 5'd16;
   localparam logic [4:0] S_DIV   = 5'd17;
   localparam logic [4:0] S_UPD   = 5'd18;
   localparam logic [4:0] S_CHK   = 5'd19;
   localparam logic [4:0] S_DONE  = 5'd20;

   logic [4:0] state_ff, state_in;
   logic [2:0] term_ff, term_in;
   logic       cos_ff, cos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] op;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      cos_in   = cos_ff;
      op       = OP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            op       = OP_ABS;
            state_in = S_RED;
         end
         S_RED: begin
            if (status.red_more) begin
               op = OP_REDUCE;
            end else begin
               op       = OP_SQR;
               state_in = S_SQRND;
            end
         end
         S_SQRND: begin
            op       = OP_SQRND;
            term_in  = 3'd0;
            cos_in   = 1'b0;
            state_in = S_HMUL;
         end
         S_HMUL: begin
            op       = OP_HMUL;
            state_in = S_HRND;
         end
         S_HRND: begin
            op       = OP_HRND;
            state_in = S_HREC;
         end
         S_HREC: begin
            op       = OP_HREC;
            state_in = S_HCOR;
         end
         S_HCOR: begin
            op = OP_HCOR;
            if (term_ff == 3'(HORNER_LAST)) begin
               state_in = cos_ff ? S_SVMUL : S_HSAVE;
            end else begin
               term_in  = term_ff + 3'd1;
               state_in = S_HMUL;
            end
         end
         S_HSAVE: begin
            // sine series done, run the cosine series next
            op       = OP_HSAVE;
            term_in  = 3'd0;
            cos_in   = 1'b1;
            state_in = S_HMUL;
         end
         S_SVMUL: begin
            op       = OP_SVMUL;
            state_in = S_SVRND;
         end
         S_SVRND: begin
            op       = OP_SVRND;
            state_in = S_QUAD;
         end
         S_QUAD: begin
            op       = OP_QUAD;
            state_in = S_ESMUL;
         end
         S_ESMUL: begin
            op       = OP_ESMUL;
            state_in = S_RES;
         end
         S_RES: begin
            op       = OP_RES;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            op       = OP_DMUL;
            state_in = S_DSET;
         end
         S_DSET: begin
            op       = OP_DSET;
            state_in = S_DIVST;
         end
         S_DIVST: begin
            op       = OP_DIVST;
            state_in = S_DIV;
         end
         S_DIV: begin
            op = OP_DIVSTEP;
            if (status.div_last) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            op       = OP_UPDATE;
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = (status.mag_ok || status.limit_hit) ? S_DONE : S_ABS;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op       = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         term_ff      <= 3'd0;
         cos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         cos_ff       <= cos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.op      = op;
   assign cmd.cos_sel = cos_ff;
   assign cmd.term    = term_ff;

endmodule

// File: hdl/kes_dpath.sv
// ----------------------------------------------------------------------------
// Kepler equation solver datapath
// Range reduction, series evaluation, residual, step division and Newton update.
// ----------------------------------------------------------------------------
module kes_dpath
   import kes_pkg::*;
(
   input  logic               clock,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [ANGLE_W-1:0] req_mean_anomaly,
   input  logic [ECC_W-1:0]   req_eccentricity,
   input  logic [ANGLE_W-1:0] req_initial_guess,
   input  logic [TOL_W-1:0]   tolerance,
   input  logic [LIMIT_W-1:0] iteration_limit,
   output logic [ANGLE_W-1:0] rsp_eccentric_anomaly,
   output logic [ANGLE_W-1:0] rsp_residual,
   output logic [LIMIT_W-1:0] rsp_passes,
   output logic               rsp_converged
);

   logic [ANGLE_W-1:0]   m_ff, ea_ff, f_ff;
   logic [ECC_W-1:0]     e_ff;
   logic [LIMIT_W-1:0]   n_ff;
   logic [33:0]          a_ff;
   logic [2:0]           quad_ff;
   logic                 neg_ff;
   logic [30:0]          r_ff;
   logic [31:0]          r2_ff;
   logic [31:0]          p_ff;
   logic [30:0]          t_ff, hs_ff, sv_ff;
   logic [63:0]          mul_ff;
   logic                 s_neg_ff, c_neg_ff;
   logic [30:0]          s_mag_ff, c_mag_ff;
   logic [47:0]          d_ff;
   logic [47:0]          rem_ff;
   logic [STEP_BITS-1:0] dvd_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;

   logic [ANGLE_W-1:0]   rsp_ea_ff, rsp_f_ff;
   logic [LIMIT_W-1:0]   rsp_n_ff;
   logic                 rsp_conv_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   always_comb begin
      case (cmd.op)
         OP_SQR:   begin mul_a = {1'b0, a_ff[30:0]}; mul_b = {1'b0, a_ff[30:0]}; end
         OP_HMUL:  begin mul_a = r2_ff;              mul_b = {1'b0, t_ff};       end
         OP_HREC:  begin mul_a = p_ff;  mul_b = horner_recip(cmd.cos_sel, cmd.term); end
         OP_SVMUL: begin mul_a = {1'b0, r_ff};       mul_b = {1'b0, hs_ff};      end
         OP_ESMUL: begin mul_a = {16'b0, e_ff};      mul_b = {1'b0, s_mag_ff};   end
         OP_DMUL:  begin mul_a = {16'b0, e_ff};      mul_b = {1'b0, c_mag_ff};   end
         default:  begin mul_a = 32'd0;              mul_b = 32'd0;              end
      endcase
   end

   // q1.30 round half up
   logic [63:0] rnd30;
   assign rnd30 = mul_ff + 64'h2000_0000;

   // horner correction of the reciprocal estimate
   logic [7:0]  hdiv;
   logic [31:0] qe;
   logic [39:0] qd, hrem;
   logic [32:0] hu;
   assign hdiv = horner_div(cmd.cos_sel, cmd.term);
   assign qe   = mul_ff[63:32];
   assign qd   = {8'b0, qe} * {32'b0, hdiv};
   assign hrem = {8'b0, p_ff} - qd;
   assign hu   = (hrem >= {32'b0, hdiv}) ? {1'b0, qe} + 33'd1 : {1'b0, qe};

   // quadrant mapping
   logic       s_neg_q, c_neg_q;
   logic [30:0] s_mag_q, c_mag_q;
   always_comb begin
      case (quad_ff[1:0])
         2'd0:    begin s_mag_q = sv_ff; s_neg_q = 1'b0; c_mag_q = t_ff;  c_neg_q = 1'b0; end
         2'd1:    begin s_mag_q = t_ff;  s_neg_q = 1'b0; c_mag_q = sv_ff; c_neg_q = 1'b1; end
         2'd2:    begin s_mag_q = sv_ff; s_neg_q = 1'b1; c_mag_q = t_ff;  c_neg_q = 1'b1; end
         default: begin s_mag_q = t_ff;  s_neg_q = 1'b1; c_mag_q = sv_ff; c_neg_q = 1'b0; end
      endcase
   end

   // residual f = E - e*sin(E) - M
   logic [47:0]        es_sum;
   logic [29:0]        es_mag;
   logic signed [35:0] es_v, f_sum;
   assign es_sum = mul_ff[47:0] + 48'h2_0000;
   assign es_mag = es_sum[47:18];
   assign es_v   = s_neg_ff ? -$signed({6'b0, es_mag}) : $signed({6'b0, es_mag});
   assign f_sum  = $signed({{4{ea_ff[31]}}, ea_ff}) - es_v
                 - $signed({{4{m_ff[31]}}, m_ff});

   // step division, one quotient bit per cycle
   logic [48:0] sh;
   logic        ge;
   logic [48:0] sh_sub;
   assign sh     = {rem_ff, dvd_ff[STEP_BITS-1]};
   assign sh_sub = sh - {1'b0, d_ff};
   assign ge     = !sh_sub[48];

   // newton update
   logic [STEP_BITS-1:0] qv;
   logic [32:0]          qc;
   logic signed [35:0]   ea_sum;
   assign qv = {1'b0, dvd_ff[STEP_BITS-1:1]} + STEP_BITS'(dvd_ff[0]);
   assign qc = (qv > STEP_BITS'(33'h1_0000_0000)) ? 33'h1_0000_0000 : qv[32:0];
   assign ea_sum = f_ff[31] ? $signed({{4{ea_ff[31]}}, ea_ff}) + $signed({3'b0, qc})
                            : $signed({{4{ea_ff[31]}}, ea_ff}) - $signed({3'b0, qc});

   logic [ANGLE_W-1:0] mag, ea_abs;
   assign mag    = f_ff[31] ? 32'd0 - f_ff : f_ff;
   assign ea_abs = ea_ff[31] ? 32'd0 - ea_ff : ea_ff;

   always_ff @(posedge clock) begin
      mul_ff <= {32'b0, mul_a} * {32'b0, mul_b};
      case (cmd.op)
         OP_LOAD: begin
            m_ff  <= req_mean_anomaly;
            e_ff  <= req_eccentricity;
            ea_ff <= req_initial_guess;
            n_ff  <= '0;
         end
         OP_ABS: begin
            a_ff    <= {ea_abs, 2'b00};
            neg_ff  <= ea_ff[31];
            quad_ff <= 3'd0;
         end
         OP_REDUCE: begin
            a_ff    <= a_ff - {3'b0, HALF_PI_Q30};
            quad_ff <= quad_ff + 3'd1;
         end
         OP_SQR: begin
            r_ff <= a_ff[30:0];
         end
         OP_SQRND: begin
            r2_ff <= rnd30[61:30];
            t_ff  <= TRIG_ONE;
         end
         OP_HRND: begin
            p_ff <= rnd30[61:30];
         end
         OP_HCOR: begin
            // partial term clamps at zero
            t_ff <= (hu >= {2'b0, TRIG_ONE}) ? 31'd0 : 31'({2'b0, TRIG_ONE} - hu);
         end
         OP_HSAVE: begin
            hs_ff <= t_ff;
            t_ff  <= TRIG_ONE;
         end
         OP_SVRND: begin
            sv_ff <= rnd30[60:30];
         end
         OP_QUAD: begin
            s_mag_ff <= s_mag_q;
            s_neg_ff <= s_neg_q ^ neg_ff;
            c_mag_ff <= c_mag_q;
            c_neg_ff <= c_neg_q;
         end
         OP_RES: begin
            f_ff <= sat_angle(f_sum);
         end
         OP_DSET: begin
            d_ff <= c_neg_ff ? 48'h4000_0000_0000 + {1'b0, mul_ff[46:0]}
                             : 48'h4000_0000_0000 - {1'b0, mul_ff[46:0]};
         end
         OP_DIVST: begin
            rem_ff <= '0;
            dvd_ff <= {mag, 47'b0};
            cnt_ff <= '0;
         end
         OP_DIVSTEP: begin
            rem_ff <= ge ? sh_sub[47:0] : sh[47:0];
            dvd_ff <= {dvd_ff[STEP_BITS-2:0], ge};
            cnt_ff <= cnt_ff + STEP_CNT_W'(1);
         end
         OP_UPDATE: begin
            ea_ff <= sat_angle(ea_sum);
            n_ff  <= n_ff + LIMIT_W'(1);
         end
         OP_OUT: begin
            rsp_ea_ff   <= ea_ff;
            rsp_f_ff    <= f_ff;
            rsp_n_ff    <= n_ff;
            rsp_conv_ff <= status.mag_ok;
         end
         default: begin
         end
      endcase
   end

   assign status.red_more  = (a_ff >= {3'b0, HALF_PI_Q30});
   assign status.div_last  = (cnt_ff == STEP_CNT_W'(STEP_BITS - 1));
   assign status.mag_ok    = (mag <= {16'b0, tolerance});
   assign status.limit_hit = (n_ff >= iteration_limit);

   assign rsp_eccentric_anomaly = rsp_ea_ff;
   assign rsp_residual          = rsp_f_ff;
   assign rsp_passes            = rsp_n_ff;
   assign rsp_converged         = rsp_conv_ff;

endmodule

// File: hdl/kepler_equation_solver_top.sv
// ----------------------------------------------------------------------------
// Kepler equation solver
// Newton-Raphson solution of E - e*sin(E) = M in signed Q3.28 radians.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Items are worked one at a
// time: each Newton pass runs the quadrant reduction, the two 7-term Horner
// series on one shared multiplier, the residual and the bit-serial step
// divider. A finished result sits in an output register while the next
// transaction is taken. The user must write tolerance (index 0) and
// iteration limit (index 1) only while the block is idle; the block itself
// does not enforce this.
module kepler_equation_solver_top
   import kes_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ANGLE_W-1:0] req_mean_anomaly,
   input  logic [ECC_W-1:0]   req_eccentricity,
   input  logic [ANGLE_W-1:0] req_initial_guess,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ANGLE_W-1:0] rsp_eccentric_anomaly,
   output logic [ANGLE_W-1:0] rsp_residual,
   output logic [LIMIT_W-1:0] rsp_passes,
   output logic               rsp_converged,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [TOL_W-1:0]   csr_wdata
);

`include "kepler_equation_solver_top_assert.svh"

   localparam logic CSR_TOLERANCE = 1'b0;
   localparam logic CSR_LIMIT     = 1'b1;

   logic [TOL_W-1:0]   tol_ff;
   logic [LIMIT_W-1:0] limit_ff;
   cmd_type            cmd;
   status_type         status;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_W'(320);
         limit_ff <= LIMIT_W'(32);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_ff   <= csr_wdata;
            CSR_LIMIT:     limit_ff <= csr_wdata[LIMIT_W-1:0];
         endcase
      end
   end

   kes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kes_dpath u_dpath (
      .clock                 (clock),
      .cmd                   (cmd),
      .status                (status),
      .req_mean_anomaly      (req_mean_anomaly),
      .req_eccentricity      (req_eccentricity),
      .req_initial_guess     (req_initial_guess),
      .tolerance             (tol_ff),
      .iteration_limit       (limit_ff),
      .rsp_eccentric_anomaly (rsp_eccentric_anomaly),
      .rsp_residual          (rsp_residual),
      .rsp_passes            (rsp_passes),
      .rsp_converged         (rsp_converged)
   );

   // busy right after taking a transaction
   `KES_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // every result made at least one pass
   `KES_ASSERT_SAME(a_passes_nonzero, clock, reset, rsp_valid, rsp_passes != 8'd0)
   // a non-converged result ran into the limit
   `KES_ASSERT_SAME(a_limit_reached, clock, reset, rsp_valid && !rsp_converged,
                    rsp_passes >= limit_ff)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kepler equation solver testbench
// Drives mean anomaly, eccentricity and guess transactions through the
// solver, predicts each Newton-Raphson solution in fixed point and checks
// every returned field, across several tolerance and limit settings.
// ----------------------------------------------------------------------------
module tb_top
   import kes_pkg::*;
;

   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_LIMIT     = 1'b1;
   localparam int   STALL_LIMIT   = 200000;
   localparam longint unsigned HALF_PI = 64'd1686629713;

   typedef struct {
      logic [ANGLE_W-1:0] anomaly;
      logic [ANGLE_W-1:0] residual;
      logic [LIMIT_W-1:0] passes;
      logic               converged;
   } solution_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [ANGLE_W-1:0] req_mean_anomaly = '0;
   logic [ECC_W-1:0]   req_eccentricity = '0;
   logic [ANGLE_W-1:0] req_initial_guess = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [ANGLE_W-1:0] rsp_eccentric_anomaly;
   logic [ANGLE_W-1:0] rsp_residual;
   logic [LIMIT_W-1:0] rsp_passes;
   logic               rsp_converged;
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [TOL_W-1:0]   csr_wdata = '0;

   solution_type    pending_solutions[$];
   solution_type    want;
   longint unsigned tol_shadow = 320;
   longint unsigned limit_shadow = 32;
   int              send_idle = 0;
   int              recv_idle = 0;
   int              mismatches = 0;
   int              stall_cycles = 0;

   kepler_equation_solver_top u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   // ---------------- fixed-point predictor ----------------
   function automatic longint clamp_angle(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned trig_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint unsigned taylor(longint unsigned r2, logic cos_sel);
      longint unsigned sin_d[7] = '{210, 156, 110, 72, 42, 20, 6};
      longint unsigned cos_d[7] = '{182, 132, 90, 56, 30, 12, 2};
      longint unsigned t, u;
      t = 64'd1 << 30;
      for (int i = 0; i < 7; i++) begin
         u = trig_mul(r2, t) / (cos_sel ? cos_d[i] : sin_d[i]);
         t = (u >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - u;
      end
      return t;
   endfunction

   task automatic sin_cos_q30(input longint ang, output longint s, output longint c);
      longint unsigned a, quad, r, r2;
      longint sv, cv, so, co;
      a = (ang < 0) ? longint'(-ang) : longint'(ang);
      a = a << 2;
      quad = a / HALF_PI;
      r = a - quad * HALF_PI;
      r2 = trig_mul(r, r);
      sv = longint'(trig_mul(r, taylor(r2, 1'b0)));
      cv = longint'(taylor(r2, 1'b1));
      case (quad[1:0])
         2'd0: begin so = sv; co = cv; end
         2'd1: begin so = cv; co = -sv; end
         2'd2: begin so = -sv; co = -cv; end
         default: begin so = -cv; co = sv; end
      endcase
      s = (ang < 0) ? -so : so;
      c = co;
   endtask

   function automatic longint round_off18(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << 17)) >> 18;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned newton_step(longint unsigned num, longint unsigned den);
      longint unsigned qv, rem;
      qv = num / den;
      rem = num % den;
      for (int i = 0; i < 46; i++) begin
         rem = rem << 1;
         qv = qv << 1;
         if (rem >= den) begin
            rem = rem - den;
            qv = qv | 64'd1;
         end
      end
      rem = rem << 1;
      if (rem >= den) qv = qv + 1;
      return qv;
   endfunction

   task automatic predict_solution(input logic [ANGLE_W-1:0] m_raw,
                                   input logic [ECC_W-1:0] e_raw,
                                   input logic [ANGLE_W-1:0] g_raw,
                                   output solution_type r);
      longint m, e, ea, f, s, c, es, d;
      longint unsigned mag, q, n;
      logic done;
      m = longint'($signed(m_raw));
      e = longint'({1'b0, e_raw});
      ea = longint'($signed(g_raw));
      n = 0;
      done = 1'b0;
      f = 0;
      r.converged = 1'b0;
      while (!done) begin
         sin_cos_q30(ea, s, c);
         es = round_off18(e * s);
         f = clamp_angle(ea - es - m);
         d = (64'sd1 << 46) - e * c;
         mag = (f < 0) ? longint'(-f) : longint'(f);
         q = newton_step(mag, longint'(d));
         if (q > (64'd1 << 32)) q = 64'd1 << 32;
         ea = clamp_angle((f < 0) ? ea + longint'(q) : ea - longint'(q));
         n = n + 1;
         if (mag <= tol_shadow) begin
            r.converged = 1'b1;
            done = 1'b1;
         end else if (n >= limit_shadow) begin
            done = 1'b1;
         end
      end
      r.anomaly = ea[ANGLE_W-1:0];
      r.residual = f[ANGLE_W-1:0];
      r.passes = n[LIMIT_W-1:0];
   endtask

   // ---------------- result checking ----------------
   task automatic note_mismatch(input string what, input logic [31:0] exp_v, act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $realtime);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_solutions.size() == 0) begin
            note_mismatch("unexpected transaction", 32'd0, rsp_eccentric_anomaly);
         end else begin
            want = pending_solutions.pop_front();
            if (rsp_eccentric_anomaly !== want.anomaly)
               note_mismatch("eccentric_anomaly", want.anomaly, rsp_eccentric_anomaly);
            if (rsp_residual !== want.residual)
               note_mismatch("residual", want.residual, rsp_residual);
            if (rsp_passes !== want.passes)
               note_mismatch("passes", 32'(want.passes), 32'(rsp_passes));
            if (rsp_converged !== want.converged)
               note_mismatch("converged", 32'(want.converged), 32'(rsp_converged));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_solve(input logic [ANGLE_W-1:0] m, input logic [ECC_W-1:0] e,
                             input logic [ANGLE_W-1:0] g);
      solution_type r;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_mean_anomaly <= m;
      req_eccentricity <= e;
      req_initial_guess <= g;
      do @(posedge clock); while (!req_ready);
      predict_solution(m, e, g, r);
      pending_solutions.push_back(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [TOL_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == REG_TOLERANCE) tol_shadow = data;
      else limit_shadow = data[LIMIT_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ANGLE_W-1:0] near_value(logic [ANGLE_W-1:0] base);
      return base + ANGLE_W'($signed($urandom_range(65535) - 32768) <<< $urandom_range(14));
   endfunction

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      send_solve(32'h1000_0000, 16'h4000, 32'h1000_0000);
      send_solve(32'h0000_0000, 16'h0000, 32'h0000_0000);
      drain_results();
   endtask

   task automatic test_field_extremes();
      write_csr(REG_LIMIT, 16'd255);
      write_csr(REG_TOLERANCE, 16'd320);
      send_solve(32'h7FFF_FFFF, 16'h0000, 32'h7FFF_FFFF);
      send_solve(32'h8000_0000, 16'hFFFF, 32'h8000_0000);
      send_solve(32'h3243_F6A8, 16'hFFFF, 32'h0000_0000);
      send_solve(32'hCDBC_0958, 16'h8000, 32'h3243_F6A8);
      send_solve(32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
      send_solve(32'h0000_0001, 16'h0001, 32'hFFFF_FFFF);
      drain_results();
   endtask

   task automatic test_limit_cases();
      // tolerance met on the very pass that hits the limit
      write_csr(REG_LIMIT, 16'd1);
      send_solve(32'h0800_0000, 16'h0000, 32'h0800_0000);
      send_solve(32'h0800_0000, 16'hC000, 32'hF000_0000);
      drain_results();
      // zero limit still makes one pass
      write_csr(REG_LIMIT, 16'd0);
      send_solve(32'h2000_0000, 16'h9000, 32'h0000_0000);
      drain_results();
      // bits above the limit width are dropped
      write_csr(REG_LIMIT, 16'hFF02);
      send_solve(32'h2000_0000, 16'h9000, 32'h0000_0000);
      drain_results();
      // zero tolerance with a long limit, runs to the cap
      write_csr(REG_TOLERANCE, 16'd0);
      write_csr(REG_LIMIT, 16'd255);
      send_solve(32'h3000_0000, 16'hFFFF, 32'h8000_0000);
      drain_results();
      write_csr(REG_TOLERANCE, 16'hFFFF);
      send_solve(32'h3000_0000, 16'hFFFF, 32'h8000_0000);
      send_solve(32'hF123_4567, 16'h7777, 32'hF123_4567);
      drain_results();
   endtask

   task automatic test_random_solves(input int s_idle, input int r_idle, input int count,
                                     input logic [TOL_W-1:0] tol, input logic [TOL_W-1:0] lim,
                                     input logic hold_off);
      logic [ANGLE_W-1:0] m, g;
      logic [ECC_W-1:0]   e;
      int                 kind;
      write_csr(REG_TOLERANCE, tol);
      write_csr(REG_LIMIT, lim);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         m = (kind < 60) ? ANGLE_W'($signed($urandom_range(32'h7000_0000)) - 32'sh3800_0000)
                         : $urandom;
         e = $urandom;
         if (kind < 75) g = near_value(m);
         else if (kind < 85) g = m;
         else g = $urandom;
         if (kind >= 95) e = (kind[0]) ? 16'hFFFF : 16'h0000;
         send_solve(m, e, g);
         if (hold_off && i == count / 2) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_limit_cases();
      test_random_solves(36, 57, 500, 16'd320, 16'd4, 1'b1);
      test_random_solves(57, 36, 500, 16'hFFFF, 16'd3, 1'b0);
      test_random_solves(0, 0, 500, 16'd40, 16'd5, 1'b0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_solutions.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/kes_pkg.sv
hdl/kes_ctrl.sv
hdl/kes_dpath.sv
hdl/kepler_equation_solver_top.sv
tb/sv/tb_top.sv
